// ===== hdl/imhq_pkg.sv =====
// ----------------------------------------------------------------------------
// imhq_pkg: shared types and codes of the indexed min-heap queue
// Field widths, request and status codes, and the item and entry records.
// ----------------------------------------------------------------------------
package imhq_pkg;

  localparam int KEY_W = 32;
  localparam int POS_W = 10;
  localparam int HND_W = 10;
  localparam int CNT_W = 11;

  localparam int HEAP_DEPTH_DEF   = 1024;
  localparam int HANDLE_COUNT_DEF = 1024;

  // Old key assumed for a fresh entry before its key is lowered into place.
  localparam logic [KEY_W-1:0] TAU_INF = '1;

  // Request codes.
  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_DELETE = 2'd1;
  localparam logic [1:0] REQ_CHANGE = 2'd2;
  localparam logic [1:0] REQ_LOCATE = 2'd3;

  // Status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_BADPOS   = 2'd2;
  localparam logic [1:0] ST_NOHANDLE = 2'd3;

  typedef struct packed {
    logic [1:0]       req;
    logic [POS_W-1:0] position;
    logic [KEY_W-1:0] key;
    logic [HND_W-1:0] handle;
  } item_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [HND_W-1:0] handle;
  } entry_t;

endpackage

// ===== hdl/imhq_front.sv =====
// ----------------------------------------------------------------------------
// imhq_front: request intake
// Takes items from the command port into a two-entry queue for the sequencer.
// ----------------------------------------------------------------------------
module imhq_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  imhq_pkg::item_t in_item,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output imhq_pkg::item_t head
);
  import imhq_pkg::*;

  item_t      slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign full       = (fill == 2'd2);
  assign head_valid = (fill != 2'd0);
  assign head       = slots[rd_ptr];

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_item;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

endmodule

// ===== hdl/imhq_back.sv =====
// ----------------------------------------------------------------------------
// imhq_back: heap sequencer
// Holds the heap and handle map memories and carries out one request at a
// time: insert, delete, key change with sifting, and handle lookup.
// ----------------------------------------------------------------------------
module imhq_back #(
  parameter int HEAP_DEPTH   = imhq_pkg::HEAP_DEPTH_DEF,
  parameter int HANDLE_COUNT = imhq_pkg::HANDLE_COUNT_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        head_valid,
  input  imhq_pkg::item_t             head,
  output logic                        pop,
  output logic                        done,
  output logic [1:0]                  status,
  output logic [imhq_pkg::KEY_W-1:0]  min_key,
  output logic [imhq_pkg::HND_W-1:0]  min_handle,
  output logic                        heap_empty,
  output logic [imhq_pkg::CNT_W-1:0]  entry_count,
  output logic [imhq_pkg::POS_W-1:0]  found_position
);
  import imhq_pkg::*;

  localparam int AW = $clog2(HEAP_DEPTH);
  localparam int HW = $clog2(HANDLE_COUNT);
  localparam int CW = $clog2(HEAP_DEPTH + 1);

  localparam logic [3:0] S_CLEAR    = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_DEL_RD   = 4'd2;
  localparam logic [3:0] S_DEL_CLR  = 4'd3;
  localparam logic [3:0] S_CHG_RD   = 4'd4;
  localparam logic [3:0] S_DISPATCH = 4'd5;
  localparam logic [3:0] S_UP_CMP   = 4'd6;
  localparam logic [3:0] S_DN_CMP   = 4'd7;
  localparam logic [3:0] S_PLACE    = 4'd8;
  localparam logic [3:0] S_LOC_RD   = 4'd9;
  localparam logic [3:0] S_DONE     = 4'd10;

  typedef struct packed {
    logic          valid;
    logic [AW-1:0] pos;
  } map_t;

  // Memories.
  entry_t heap_mem [HEAP_DEPTH];
  map_t   map_mem  [HANDLE_COUNT];

  logic          heap_we;
  logic [AW-1:0] heap_wa;
  entry_t        heap_wd;
  logic [AW-1:0] ra_a;
  logic [AW-1:0] ra_b;
  entry_t        heap_q_a;
  entry_t        heap_q_b;
  logic          map_we;
  logic [HW-1:0] map_wa;
  map_t          map_wd;
  logic [HW-1:0] map_ra;
  map_t          map_q;

  // Control and working registers.
  logic [3:0]       state, state_next;
  logic [HW-1:0]    clr_idx, clr_idx_next;
  logic [CW-1:0]    cnt, cnt_next;
  logic [AW-1:0]    hole, hole_next;
  entry_t           cur, cur_next;
  logic [KEY_W-1:0] old_key, old_key_next;
  logic [HND_W-1:0] del_hnd, del_hnd_next;
  logic             del_last, del_last_next;
  logic             moved, moved_next;
  logic [1:0]       stat, stat_next;
  logic [POS_W-1:0] found, found_next;
  entry_t           root;

  // Index arithmetic around the hole.
  logic [31:0]   hole32, cnt32, left32, right32, cl32;
  logic [AW-1:0] parent, grand;
  logic          lt, rt;
  logic [KEY_W-1:0] kmin;
  logic [AW-1:0] child;
  entry_t        child_e;

  function automatic logic hnd_ok(input logic [HND_W-1:0] h);
    return 32'(h) < 32'(HANDLE_COUNT);
  endfunction

  assign hole32  = 32'(hole);
  assign cnt32   = 32'(cnt);
  assign left32  = 2 * hole32 + 32'd1;
  assign right32 = left32 + 32'd1;
  assign parent  = AW'((hole32 - 32'd1) >> 1);
  assign grand   = AW'((32'(parent) - 32'd1) >> 1);

  // Smaller-child selection for sifting down.
  always_comb begin
    lt      = (left32 < cnt32) && (heap_q_a.key < cur.key);
    kmin    = lt ? heap_q_a.key : cur.key;
    rt      = (right32 < cnt32) && (heap_q_b.key < kmin);
    child   = rt ? AW'(right32) : AW'(left32);
    child_e = rt ? heap_q_b : heap_q_a;
    cl32    = 2 * 32'(child) + 32'd1;
  end

  // Sequencer next-state and memory control.
  always_comb begin
    state_next    = state;
    clr_idx_next  = clr_idx;
    cnt_next      = cnt;
    hole_next     = hole;
    cur_next      = cur;
    old_key_next  = old_key;
    del_hnd_next  = del_hnd;
    del_last_next = del_last;
    moved_next    = moved;
    stat_next     = stat;
    found_next    = found;
    pop           = 1'b0;
    heap_we       = 1'b0;
    heap_wa       = hole;
    heap_wd       = cur;
    ra_a          = hole;
    ra_b          = hole;
    map_we        = 1'b0;
    map_wa        = '0;
    map_wd        = '0;
    map_ra        = HW'(head.handle);

    case (state)
      S_CLEAR: begin
        map_we = 1'b1;
        map_wa = clr_idx;
        if (clr_idx == HW'(HANDLE_COUNT - 1)) begin
          state_next = S_IDLE;
        end else begin
          clr_idx_next = clr_idx + 1'b1;
        end
      end

      S_IDLE: begin
        if (head_valid) begin
          pop        = 1'b1;
          stat_next  = ST_OK;
          found_next = '0;
          moved_next = 1'b0;
          case (head.req)
            REQ_INSERT: begin
              if (cnt32 >= 32'(HEAP_DEPTH)) begin
                stat_next  = ST_FULL;
                state_next = S_DONE;
              end else begin
                hole_next    = AW'(cnt);
                cur_next     = '{key: head.key, handle: head.handle};
                old_key_next = TAU_INF;
                cnt_next     = cnt + 1'b1;
                if (hnd_ok(head.handle)) begin
                  map_we = 1'b1;
                  map_wa = HW'(head.handle);
                  map_wd = '{valid: 1'b1, pos: AW'(cnt)};
                end
                state_next = S_DISPATCH;
              end
            end
            REQ_DELETE, REQ_CHANGE: begin
              if (32'(head.position) >= cnt32) begin
                stat_next  = ST_BADPOS;
                state_next = S_DONE;
              end else begin
                hole_next    = AW'(head.position);
                ra_a         = AW'(head.position);
                ra_b         = AW'(cnt - 1'b1);
                cur_next.key = head.key;
                state_next   = (head.req == REQ_DELETE) ? S_DEL_RD : S_CHG_RD;
              end
            end
            default: begin
              if (!hnd_ok(head.handle)) begin
                stat_next  = ST_NOHANDLE;
                state_next = S_DONE;
              end else begin
                state_next = S_LOC_RD;
              end
            end
          endcase
        end
      end

      // The last entry moves into the addressed slot.
      S_DEL_RD: begin
        cur_next      = heap_q_b;
        old_key_next  = heap_q_a.key;
        del_hnd_next  = heap_q_a.handle;
        del_last_next = (hole == AW'(cnt - 1'b1));
        cnt_next      = cnt - 1'b1;
        if (hnd_ok(heap_q_b.handle)) begin
          map_we = 1'b1;
          map_wa = HW'(heap_q_b.handle);
          map_wd = '{valid: 1'b1, pos: hole};
        end
        state_next = S_DEL_CLR;
      end

      // The removed handle leaves the map after the move is recorded.
      S_DEL_CLR: begin
        if (hnd_ok(del_hnd)) begin
          map_we = 1'b1;
          map_wa = HW'(del_hnd);
        end
        state_next = del_last ? S_DONE : S_DISPATCH;
      end

      S_CHG_RD: begin
        cur_next.handle = heap_q_a.handle;
        old_key_next    = heap_q_a.key;
        state_next      = S_DISPATCH;
      end

      // Choose the sift direction from the old and new keys.
      S_DISPATCH: begin
        if (cur.key > old_key) begin
          if (left32 < cnt32) begin
            ra_a       = AW'(left32);
            ra_b       = AW'(right32);
            state_next = S_DN_CMP;
          end else begin
            state_next = S_PLACE;
          end
        end else if (cur.key < old_key && hole != '0) begin
          ra_a       = parent;
          state_next = S_UP_CMP;
        end else begin
          state_next = S_PLACE;
        end
      end

      // One level upward: the parent drops into the hole if it is larger.
      S_UP_CMP: begin
        if (heap_q_a.key > cur.key) begin
          heap_we    = 1'b1;
          heap_wd    = heap_q_a;
          moved_next = 1'b1;
          hole_next  = parent;
          if (hnd_ok(heap_q_a.handle)) begin
            map_we = 1'b1;
            map_wa = HW'(heap_q_a.handle);
            map_wd = '{valid: 1'b1, pos: hole};
          end
          if (parent == '0) begin
            state_next = S_PLACE;
          end else begin
            ra_a = grand;
          end
        end else begin
          state_next = S_PLACE;
        end
      end

      // One level downward: the smaller child rises into the hole.
      S_DN_CMP: begin
        if (lt || rt) begin
          heap_we    = 1'b1;
          heap_wd    = child_e;
          moved_next = 1'b1;
          hole_next  = child;
          if (hnd_ok(child_e.handle)) begin
            map_we = 1'b1;
            map_wa = HW'(child_e.handle);
            map_wd = '{valid: 1'b1, pos: hole};
          end
          if (cl32 < cnt32) begin
            ra_a = AW'(cl32);
            ra_b = AW'(cl32 + 32'd1);
          end else begin
            state_next = S_PLACE;
          end
        end else begin
          state_next = S_PLACE;
        end
      end

      S_PLACE: begin
        heap_we = 1'b1;
        if (moved && hnd_ok(cur.handle)) begin
          map_we = 1'b1;
          map_wa = HW'(cur.handle);
          map_wd = '{valid: 1'b1, pos: hole};
        end
        state_next = S_DONE;
      end

      S_LOC_RD: begin
        if (map_q.valid) begin
          found_next = POS_W'(map_q.pos);
        end else begin
          stat_next = ST_NOHANDLE;
        end
        state_next = S_DONE;
      end

      S_DONE: begin
        state_next = S_IDLE;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Heap memory with two registered read ports.
  always_ff @(posedge clk) begin
    if (heap_we) begin
      heap_mem[heap_wa] <= heap_wd;
    end
    heap_q_a <= heap_mem[ra_a];
    heap_q_b <= heap_mem[ra_b];
  end

  // Handle map memory.
  always_ff @(posedge clk) begin
    if (map_we) begin
      map_mem[map_wa] <= map_wd;
    end
    map_q <= map_mem[map_ra];
  end

  // Working registers and the mirror of the root entry.
  always_ff @(posedge clk) begin
    hole     <= hole_next;
    cur      <= cur_next;
    old_key  <= old_key_next;
    del_hnd  <= del_hnd_next;
    del_last <= del_last_next;
    moved    <= moved_next;
    stat     <= stat_next;
    found    <= found_next;
    if (heap_we && heap_wa == '0) begin
      root <= heap_wd;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_idx <= '0;
      cnt     <= '0;
    end else begin
      state   <= state_next;
      clr_idx <= clr_idx_next;
      cnt     <= cnt_next;
    end
  end

  // Result ports.
  assign done           = (state == S_DONE);
  assign status         = stat;
  assign heap_empty     = (cnt == '0);
  assign min_key        = heap_empty ? '0 : root.key;
  assign min_handle     = heap_empty ? '0 : root.handle;
  assign entry_count    = CNT_W'(cnt);
  assign found_position = found;

endmodule

// ===== hdl/indexed_min_heap_queue.sv =====
// ----------------------------------------------------------------------------
// indexed_min_heap_queue: indexed binary min-heap of event times
// Keys with owner handles in a heap memory, plus a handle-to-position map.
// ----------------------------------------------------------------------------
// Usage: raise start with req_type, position, new_key and item_handle; the
// item is taken on a clock edge where busy is low. A two-entry request queue
// sits in front of the sequencer, so up to two items wait while one runs.
// Each item yields one result, shown for exactly one cycle with done high:
// status, root key and handle, heap_empty, entry_count and found_position.
// The receiver cannot stall; results must be taken as they come.
// Requests that fail at intake (full heap, bad position, handle out of range)
// go straight to their result, and a delete of the last entry skips the sift.
// In the sift loop one registered memory read feeds one compare and write per
// heap level the entry moves. After reset the handle map is swept clear, one
// handle per cycle; items queue meanwhile but are not carried out.
// ----------------------------------------------------------------------------
module indexed_min_heap_queue #(
  parameter int HEAP_DEPTH   = imhq_pkg::HEAP_DEPTH_DEF,
  parameter int HANDLE_COUNT = imhq_pkg::HANDLE_COUNT_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  req_type,
  input  logic [imhq_pkg::POS_W-1:0]  position,
  input  logic [imhq_pkg::KEY_W-1:0]  new_key,
  input  logic [imhq_pkg::HND_W-1:0]  item_handle,
  output logic                        done,
  output logic [1:0]                  status,
  output logic [imhq_pkg::KEY_W-1:0]  min_key,
  output logic [imhq_pkg::HND_W-1:0]  min_handle,
  output logic                        heap_empty,
  output logic [imhq_pkg::CNT_W-1:0]  entry_count,
  output logic [imhq_pkg::POS_W-1:0]  found_position
);
  import imhq_pkg::*;

  item_t in_item;
  item_t head;
  logic  full;
  logic  head_valid;
  logic  pop;

  assign in_item = '{req: req_type, position: position, key: new_key, handle: item_handle};
  assign busy    = full;

  imhq_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (start && !busy),
    .in_item    (in_item),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  imhq_back #(
    .HEAP_DEPTH   (HEAP_DEPTH),
    .HANDLE_COUNT (HANDLE_COUNT)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .head_valid     (head_valid),
    .head           (head),
    .pop            (pop),
    .done           (done),
    .status         (status),
    .min_key        (min_key),
    .min_handle     (min_handle),
    .heap_empty     (heap_empty),
    .entry_count    (entry_count),
    .found_position (found_position)
  );

endmodule

// ===== dv/tb_indexed_min_heap_queue.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_indexed_min_heap_queue: self-checking bench for the indexed min-heap
// Requests are driven through the start/busy handshake. A directed table is
// walked first, then random traffic. A behavioral heap with its own handle
// map predicts every result, and each done cycle is checked field by field.
// ----------------------------------------------------------------------------
module tb_indexed_min_heap_queue;
  import imhq_pkg::*;

  localparam int DEPTH   = 1024;
  localparam int HANDLES = 1024;

  typedef struct packed {
    logic [1:0]       st;
    logic [KEY_W-1:0] mkey;
    logic [HND_W-1:0] mhnd;
    logic             empty;
    logic [CNT_W-1:0] cnt;
    logic [POS_W-1:0] fpos;
  } outcome_t;

  // One directed row; has_fixed marks an expectation typed in by hand.
  typedef struct {
    item_t    it;
    bit       has_fixed;
    outcome_t fixed;
  } row_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic [1:0]       req_type = '0;
  logic [POS_W-1:0] position = '0;
  logic [KEY_W-1:0] new_key = '0;
  logic [HND_W-1:0] item_handle = '0;
  logic             busy, done, heap_empty;
  logic [1:0]       status;
  logic [KEY_W-1:0] min_key;
  logic [HND_W-1:0] min_handle;
  logic [CNT_W-1:0] entry_count;
  logic [POS_W-1:0] found_position;

  indexed_min_heap_queue dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .req_type(req_type), .position(position), .new_key(new_key),
    .item_handle(item_handle), .done(done), .status(status),
    .min_key(min_key), .min_handle(min_handle), .heap_empty(heap_empty),
    .entry_count(entry_count), .found_position(found_position)
  );

  always #4 clk = ~clk;

  // Predicted heap contents and handle map.
  logic [KEY_W-1:0] pk[DEPTH];
  logic [HND_W-1:0] ph[DEPTH];
  int               pmap[HANDLES];
  bit               pvalid[HANDLES];
  int               pcount;

  outcome_t pending_results[$];
  row_t     rows[$];
  int       error_count = 0;
  int       idle_pct = 0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // Append one expectation at the tail of the queue.
  function automatic void add_expected(outcome_t o);
    pending_results = {pending_results, o};
  endfunction

  // Append one row to the directed table.
  function automatic void add_row(item_t it, bit has_fixed, outcome_t fixed);
    row_t r;
    r.it = it;
    r.has_fixed = has_fixed;
    r.fixed = fixed;
    rows = {rows, r};
  endfunction

  function automatic void heap_swap(int a, int b);
    logic [KEY_W-1:0] k;
    logic [HND_W-1:0] h;
    k = pk[a]; h = ph[a];
    pk[a] = pk[b]; ph[a] = ph[b];
    pk[b] = k; ph[b] = h;
    pmap[ph[a]] = a; pvalid[ph[a]] = 1'b1;
    pmap[ph[b]] = b; pvalid[ph[b]] = 1'b1;
  endfunction

  // Move the entry at idx toward the leaves until no child is smaller.
  function automatic void sink(int idx);
    int l, r, m;
    while (idx < pcount) begin
      l = 2 * idx + 1;
      r = l + 1;
      m = idx;
      if (l < pcount && pk[l] < pk[m]) m = l;
      if (r < pcount && pk[r] < pk[m]) m = r;
      if (m == idx) break;
      heap_swap(idx, m);
      idx = m;
    end
  endfunction

  function automatic void rise(int idx);
    int p;
    while (idx > 0) begin
      p = (idx - 1) / 2;
      if (!(pk[p] > pk[idx])) break;
      heap_swap(idx, p);
      idx = p;
    end
  endfunction

  function automatic void rekey(int idx, logic [KEY_W-1:0] key);
    if (key > pk[idx]) begin
      pk[idx] = key;
      sink(idx);
    end else if (key < pk[idx]) begin
      pk[idx] = key;
      rise(idx);
    end
  endfunction

  // Apply one request to the predicted heap and return the expected result.
  function automatic outcome_t heap_apply(item_t it);
    outcome_t o;
    int last;
    logic [KEY_W-1:0] last_key;
    o.st = ST_OK;
    o.fpos = '0;
    case (it.req)
      REQ_INSERT: begin
        if (pcount >= DEPTH) o.st = ST_FULL;
        else begin
          pk[pcount] = TAU_INF;
          ph[pcount] = it.handle;
          pmap[it.handle] = pcount;
          pvalid[it.handle] = 1'b1;
          pcount++;
          rekey(pcount - 1, it.key);
        end
      end
      REQ_DELETE: begin
        if (it.position >= pcount) o.st = ST_BADPOS;
        else begin
          last = pcount - 1;
          last_key = pk[last];
          pmap[ph[last]] = it.position;
          pvalid[ph[last]] = 1'b1;
          pvalid[ph[it.position]] = 1'b0;
          pmap[ph[it.position]] = 0;
          ph[it.position] = ph[last];
          pcount = last;
          if (it.position != last) rekey(it.position, last_key);
        end
      end
      REQ_CHANGE: begin
        if (it.position >= pcount) o.st = ST_BADPOS;
        else rekey(it.position, it.key);
      end
      default: begin
        if (!pvalid[it.handle]) o.st = ST_NOHANDLE;
        else o.fpos = POS_W'(pmap[it.handle]);
      end
    endcase
    o.mkey = pcount > 0 ? pk[0] : '0;
    o.mhnd = pcount > 0 ? ph[0] : '0;
    o.empty = (pcount == 0);
    o.cnt = CNT_W'(pcount);
    return o;
  endfunction

  // Drive one item and hold it until the block takes it. Start stays high
  // into the next item; an idle gap or a drain lowers it.
  task automatic send_item(item_t it);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    req_type <= it.req;
    position <= it.position;
    new_key <= it.key;
    item_handle <= it.handle;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  // Check each result against the oldest expectation.
  always @(posedge clk) begin
    outcome_t w;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $display("result with nothing expected at %0t", $realtime);
        error_count++;
      end else begin
        w = pending_results.pop_front();
        if (status !== w.st) report_mismatch("status", 32'(status), 32'(w.st));
        if (min_key !== w.mkey) report_mismatch("min_key", min_key, w.mkey);
        if (min_handle !== w.mhnd)
          report_mismatch("min_handle", 32'(min_handle), 32'(w.mhnd));
        if (heap_empty !== w.empty)
          report_mismatch("heap_empty", 32'(heap_empty), 32'(w.empty));
        if (entry_count !== w.cnt)
          report_mismatch("entry_count", 32'(entry_count), 32'(w.cnt));
        if (found_position !== w.fpos)
          report_mismatch("found_position", 32'(found_position), 32'(w.fpos));
      end
    end
  end

  // Expectation is queued at the accepting edge, before the result can show.
  always @(posedge clk) begin
    if (!rst && start && !busy) add_expected(heap_apply(
      item_t'{req: req_type, position: position, key: new_key, handle: item_handle}));
  end

  function automatic item_t mk(logic [1:0] r, int p, logic [KEY_W-1:0] k, int h);
    item_t it;
    it.req = r; it.position = POS_W'(p); it.key = k; it.handle = HND_W'(h);
    return it;
  endfunction

  function automatic outcome_t fx(logic [1:0] s, logic [KEY_W-1:0] k, int h,
                                  bit e, int c, int f);
    outcome_t o;
    o.st = s; o.mkey = k; o.mhnd = HND_W'(h); o.empty = e;
    o.cnt = CNT_W'(c); o.fpos = POS_W'(f);
    return o;
  endfunction

  // Random request: mostly well-formed against the current heap size.
  function automatic item_t random_item(int fill_bias);
    item_t it;
    int sel;
    it.key = $urandom();
    if ($urandom_range(3) == 0) it.key = $urandom_range(64);
    it.handle = HND_W'($urandom_range(HANDLES - 1));
    it.position = pcount > 0 ? POS_W'($urandom_range(pcount - 1)) : '0;
    if ($urandom_range(15) == 0) it.position = POS_W'($urandom());
    sel = $urandom_range(99);
    if (sel < fill_bias) it.req = REQ_INSERT;
    else if (sel < fill_bias + (100 - fill_bias) / 3) it.req = REQ_DELETE;
    else if (sel < 90) it.req = REQ_CHANGE;
    else it.req = REQ_LOCATE;
    return it;
  endfunction

  task automatic drain_results();
    start <= 1'b0;
    while (pending_results.size() > 0) @(negedge clk);
  endtask

  initial begin
    #8_000_000;
    $display("[indexed_min_heap_queue] ERROR");
    $finish;
  end

  initial begin
    item_t it;
    int phase;
    for (int i = 0; i < HANDLES; i++) begin
      pvalid[i] = 1'b0;
      pmap[i] = 0;
    end
    pcount = 0;

    // Directed table: empty-heap errors, extremes, every request and ties.
    add_row(mk(REQ_LOCATE, 0, 0, 5), 1, fx(ST_NOHANDLE, 0, 0, 1, 0, 0));
    add_row(mk(REQ_DELETE, 0, 0, 0), 1, fx(ST_BADPOS, 0, 0, 1, 0, 0));
    add_row(mk(REQ_CHANGE, 1023, '1, 0), 1, fx(ST_BADPOS, 0, 0, 1, 0, 0));
    add_row(mk(REQ_INSERT, 0, '1, 1023), 1, fx(ST_OK, '1, 1023, 0, 1, 0));
    add_row(mk(REQ_INSERT, 0, 0, 0), 1, fx(ST_OK, 0, 0, 0, 2, 0));
    add_row(mk(REQ_LOCATE, 0, 0, 1023), 1, fx(ST_OK, 0, 0, 0, 2, 1));
    add_row(mk(REQ_INSERT, 0, 32'h0001_8000, 7), 0, fx(0, 0, 0, 0, 0, 0));
    add_row(mk(REQ_INSERT, 0, 32'h0001_8000, 8), 0, fx(0, 0, 0, 0, 0, 0));
    add_row(mk(REQ_INSERT, 0, 5, 7), 0, fx(0, 0, 0, 0, 0, 0));
    add_row(mk(REQ_CHANGE, 0, '1, 0), 0, fx(0, 0, 0, 0, 0, 0));
    add_row(mk(REQ_CHANGE, 2, 32'h0001_8000, 0), 0, fx(0, 0, 0, 0, 0, 0));
    add_row(mk(REQ_CHANGE, 4, 1, 0), 0, fx(0, 0, 0, 0, 0, 0));
    add_row(mk(REQ_LOCATE, 0, 0, 7), 0, fx(0, 0, 0, 0, 0, 0));
    add_row(mk(REQ_DELETE, 4, 0, 0), 0, fx(0, 0, 0, 0, 0, 0));
    add_row(mk(REQ_DELETE, 0, 0, 0), 0, fx(0, 0, 0, 0, 0, 0));
    add_row(mk(REQ_DELETE, 1023, 0, 0), 0, fx(0, 0, 0, 0, 0, 0));
    add_row(mk(REQ_LOCATE, 0, 0, 0), 0, fx(0, 0, 0, 0, 0, 0));
    add_row(mk(REQ_INSERT, 682, 32'hAAAA_5555, 682), 0, fx(0, 0, 0, 0, 0, 0));
    add_row(mk(REQ_INSERT, 341, 32'h5555_AAAA, 341), 0, fx(0, 0, 0, 0, 0, 0));
    add_row(mk(REQ_LOCATE, 0, 0, 341), 0, fx(0, 0, 0, 0, 0, 0));

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Hand-typed expectations are checked against the predictor as it runs.
    foreach (rows[i]) begin
      send_item(rows[i].it);
      if (rows[i].has_fixed && pending_results.size() > 0) begin
        if (pending_results[$] !== rows[i].fixed) begin
          $display("directed row %0d disagrees with its typed result", i);
          error_count++;
        end
        pending_results[$] = rows[i].fixed;
      end
    end
    drain_results();

    // Random phases with different sender idling; one fills the heap to full.
    for (phase = 0; phase < 5; phase++) begin
      case (phase)
        0: idle_pct = 0;
        1: idle_pct = 47;
        2: idle_pct = 6;
        default: idle_pct = 0;
      endcase
      if (phase == 3) begin
        // Fill until full, then push four rejected inserts and eight random requests.
        while (pcount < DEPTH) begin
          it = mk(REQ_INSERT, 0, $urandom(), $urandom_range(HANDLES - 1));
          if ($urandom_range(1)) it.key = $urandom_range(4) << $urandom_range(31);
          send_item(it);
        end
        repeat (4) send_item(mk(REQ_INSERT, $urandom(), $urandom(), $urandom()));
        repeat (8) send_item(random_item(10));
        drain_results();
        continue;
      end
      for (int n = 0; n < 100; n++) send_item(random_item(phase == 4 ? 30 : 45));
      if (phase == 1) drain_results();
    end

    drain_results();
    repeat (60) @(posedge clk);
    if (error_count == 0) $display("[indexed_min_heap_queue] OK");
    else $display("[indexed_min_heap_queue] ERROR");
    $finish;
  end

endmodule
